// File: design/csw_pkg.sv
// Shared types, constants and the sigmoid breakpoint table for the clamped SwiGLU block.
// No dependencies; every design file imports this package.
package csw_pkg;

    localparam int SigSegments = 32;
    localparam int SegIdxW     = $clog2(SigSegments);
    localparam int PosW        = 24 + SegIdxW + 1;

    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 16;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_ALPHA_GAIN  = 2'd0,
        CFG_CLAMP_LIMIT = 2'd1
    } cfg_reg_e;

    typedef struct packed {
        logic signed [15:0] gate_value;
        logic signed [15:0] up_value;
    } request_t;

    typedef struct packed {
        logic signed [15:0] product;
        logic               saturated;
    } result_t;

    // after clamp and scale
    typedef struct packed {
        logic signed [15:0] gate;
        logic signed [16:0] up_bias;
        logic signed [32:0] z;
    } front_t;

    // after sigmoid
    typedef struct packed {
        logic signed [15:0] gate;
        logic signed [16:0] up_bias;
        logic        [16:0] sig;
    } gated_t;

    // sigmoid(-8 + 16k/S) in unsigned Q16
    function automatic logic [16:0] sig_point(input logic [SegIdxW:0] k);
        logic [16:0] v;
        case (k)
            6'd0:    v = 17'd22;
            6'd1:    v = 17'd36;
            6'd2:    v = 17'd60;
            6'd3:    v = 17'd98;
            6'd4:    v = 17'd162;
            6'd5:    v = 17'd267;
            6'd6:    v = 17'd439;
            6'd7:    v = 17'd720;
            6'd8:    v = 17'd1179;
            6'd9:    v = 17'd1921;
            6'd10:   v = 17'd3108;
            6'd11:   v = 17'd4971;
            6'd12:   v = 17'd7812;
            6'd13:   v = 17'd11955;
            6'd14:   v = 17'd17625;
            6'd15:   v = 17'd24743;
            6'd16:   v = 17'd32768;
            6'd17:   v = 17'd40793;
            6'd18:   v = 17'd47911;
            6'd19:   v = 17'd53581;
            6'd20:   v = 17'd57724;
            6'd21:   v = 17'd60565;
            6'd22:   v = 17'd62428;
            6'd23:   v = 17'd63615;
            6'd24:   v = 17'd64357;
            6'd25:   v = 17'd64816;
            6'd26:   v = 17'd65097;
            6'd27:   v = 17'd65269;
            6'd28:   v = 17'd65374;
            6'd29:   v = 17'd65438;
            6'd30:   v = 17'd65476;
            6'd31:   v = 17'd65500;
            6'd32:   v = 17'd65514;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

// File: design/csw_front.sv
// Configuration registers, operand clamping and gate scaling (first pipeline stage).
// Depends on csw_pkg.
module csw_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [csw_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [csw_pkg::CfgDataW-1:0]    cfg_data,
    input  logic                            in_valid,
    input  csw_pkg::request_t               request,
    output logic                            s1_valid,
    output csw_pkg::front_t                 s1
);
    import csw_pkg::*;

    logic [15:0]        alpha_gain_reg;
    logic [14:0]        clamp_limit_reg;
    logic               valid_reg;
    front_t             data_reg;
    front_t             data_next;

    logic signed [16:0] limit_pos;
    logic signed [16:0] limit_neg;
    logic signed [16:0] gate_ext;
    logic signed [16:0] up_ext;
    logic signed [16:0] up_clamp;
    logic signed [15:0] gate_clamp;
    logic signed [33:0] z_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_gain_reg  <= 16'd6971;
            clamp_limit_reg <= 15'd1792;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_e'(cfg_index))
                CFG_ALPHA_GAIN:  alpha_gain_reg  <= cfg_data;
                CFG_CLAMP_LIMIT: clamp_limit_reg <= cfg_data[14:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        limit_pos  = $signed({2'b00, clamp_limit_reg});
        limit_neg  = -limit_pos;
        gate_ext   = {request.gate_value[15], request.gate_value};
        up_ext     = {request.up_value[15], request.up_value};
        gate_clamp = (gate_ext > limit_pos) ? limit_pos[15:0] : request.gate_value;
        if (up_ext > limit_pos)
        begin
            up_clamp = limit_pos;
        end
        else if (up_ext < limit_neg)
        begin
            up_clamp = limit_neg;
        end
        else
        begin
            up_clamp = up_ext;
        end
        z_full            = gate_clamp * $signed({1'b0, alpha_gain_reg});
        data_next.gate    = gate_clamp;
        data_next.up_bias = up_clamp + 17'sd256;
        data_next.z       = z_full[32:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign s1_valid = valid_reg;
    assign s1       = data_reg;

endmodule

// File: design/csw_sigmoid.sv
// Piecewise-linear sigmoid: segment lookup stage, then interpolation stage.
// Depends on csw_pkg (breakpoint table, stage types).
module csw_sigmoid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  csw_pkg::front_t   s1,
    output logic              s3_valid,
    output csw_pkg::gated_t   s3
);
    import csw_pkg::*;

    // lookup stage
    logic               lk_valid_reg;
    logic               lk_under_reg;
    logic               lk_over_reg;
    logic [16:0]        lk_base_reg;
    logic [15:0]        lk_diff_reg;
    logic [15:0]        lk_frac_reg;
    logic signed [15:0] lk_gate_reg;
    logic signed [16:0] lk_up_reg;

    logic               lk_under_next;
    logic               lk_over_next;
    logic [16:0]        lk_base_next;
    logic [15:0]        lk_diff_next;
    logic [15:0]        lk_frac_next;

    logic [32:0]        z_off;
    logic [PosW-1:0]    pos_full;
    logic [SegIdxW:0]   seg_lo;
    logic [SegIdxW:0]   seg_hi;
    logic [16:0]        point_hi;

    // interpolation stage
    logic               ip_valid_reg;
    gated_t             ip_data_reg;
    gated_t             ip_data_next;
    logic [32:0]        interp;

    always_comb
    begin
        lk_under_next = (s1.z < -33'sd8388608);
        lk_over_next  = (s1.z >= 33'sd8388608);
        z_off         = s1.z + 33'sd8388608;
        pos_full      = PosW'(z_off[23:0]) * PosW'(SigSegments);
        seg_lo        = {1'b0, pos_full[24 +: SegIdxW]};
        seg_hi        = seg_lo + (SegIdxW + 1)'(1);
        lk_base_next  = sig_point(seg_lo);
        point_hi      = sig_point(seg_hi);
        lk_diff_next  = 16'(point_hi - lk_base_next);
        lk_frac_next  = pos_full[23:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk_valid_reg <= 1'b0;
            ip_valid_reg <= 1'b0;
        end
        else
        begin
            lk_valid_reg <= s1_valid;
            ip_valid_reg <= lk_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lk_under_reg <= lk_under_next;
        lk_over_reg  <= lk_over_next;
        lk_base_reg  <= lk_base_next;
        lk_diff_reg  <= lk_diff_next;
        lk_frac_reg  <= lk_frac_next;
        lk_gate_reg  <= s1.gate;
        lk_up_reg    <= s1.up_bias;
    end

    always_comb
    begin
        interp = {lk_base_reg, 16'd0} + 33'(lk_diff_reg * lk_frac_reg) + 33'd32768;
        ip_data_next.gate    = lk_gate_reg;
        ip_data_next.up_bias = lk_up_reg;
        if (lk_under_reg)
        begin
            ip_data_next.sig = 17'd0;
        end
        else if (lk_over_reg)
        begin
            ip_data_next.sig = 17'd65536;
        end
        else
        begin
            ip_data_next.sig = interp[32:16];
        end
    end

    always_ff @(posedge clk)
    begin
        ip_data_reg <= ip_data_next;
    end

    assign s3_valid = ip_valid_reg;
    assign s3       = ip_data_reg;

endmodule

// File: design/csw_product.sv
// Final product: gate times sigmoid, times biased up value, then round and saturate.
// Depends on csw_pkg; three register stages ending in the result register.
module csw_product (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s3_valid,
    input  csw_pkg::gated_t   s3,
    output logic              result_valid,
    output csw_pkg::result_t  result
);
    import csw_pkg::*;

    logic               m1_valid_reg;
    logic signed [33:0] m1_prod_reg;
    logic signed [16:0] m1_up_reg;
    logic signed [33:0] m1_prod_next;

    logic               m2_valid_reg;
    logic signed [50:0] m2_acc_reg;
    logic signed [50:0] m2_acc_next;

    logic               out_valid_reg;
    result_t            out_reg;
    result_t            out_next;

    logic [50:0]        mag;
    logic [50:0]        mag_round;
    logic [26:0]        rounded;

    assign m1_prod_next = s3.gate * $signed({1'b0, s3.sig});
    assign m2_acc_next  = m1_prod_reg * m1_up_reg;

    always_comb
    begin
        mag       = m2_acc_reg[50] ? 51'(-m2_acc_reg) : 51'(m2_acc_reg);
        mag_round = mag + 51'd8388608;
        rounded   = mag_round[50:24];
        if (m2_acc_reg[50])
        begin
            if (rounded > 27'd32768)
            begin
                out_next.product   = 16'sh8000;
                out_next.saturated = 1'b1;
            end
            else
            begin
                out_next.product   = $signed(16'(~rounded[15:0] + 16'd1));
                out_next.saturated = 1'b0;
            end
        end
        else
        begin
            if (rounded > 27'd32767)
            begin
                out_next.product   = 16'sh7fff;
                out_next.saturated = 1'b1;
            end
            else
            begin
                out_next.product   = $signed(rounded[15:0]);
                out_next.saturated = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg  <= s3_valid;
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_prod_reg <= m1_prod_next;
        m1_up_reg   <= s3.up_bias;
        m2_acc_reg  <= m2_acc_next;
        out_reg     <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: design/clamped_swiglu_activation.sv
// Clamped SwiGLU activation, six-stage pipeline; depends on csw_pkg and the csw_* stages.
// Path to result_valid: front, lookup, interpolation, m1, m2 and output registers.
// Throughput: one request per clock; busy stays low, so start is taken every cycle.
// The receiver cannot stall: result is valid only during the single result_valid cycle.
// Reset (rst_n low, asynchronous) empties the pipeline and restores the register defaults.
module clamped_swiglu_activation (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  csw_pkg::request_t               request,
    output logic                            result_valid,
    output csw_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [csw_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [csw_pkg::CfgDataW-1:0]    cfg_data
);
    import csw_pkg::*;

    logic    s1_valid;
    front_t  s1;
    logic    s3_valid;
    gated_t  s3;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    csw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (start & ~busy),
        .request   (request),
        .s1_valid  (s1_valid),
        .s1        (s1)
    );

    csw_sigmoid u_sigmoid (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1       (s1),
        .s3_valid (s3_valid),
        .s3       (s3)
    );

    csw_product u_product (
        .clk          (clk),
        .rst_n        (rst_n),
        .s3_valid     (s3_valid),
        .s3           (s3),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
